// ===== design/hee_pkg.sv =====
// ----------------------------------------------------------------------------
// hee_pkg
// Shared types, constants and helper functions of the HTML entity escaper.
// ----------------------------------------------------------------------------
`default_nettype none

package hee_pkg;

  localparam int CP_W    = 21;
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 4;
  localparam int POS_W   = 3;
  localparam int DIGIT_W = 4;

  localparam logic [CP_W-1:0] CP_HT    = 21'd9;
  localparam logic [CP_W-1:0] CP_CR    = 21'd13;
  localparam logic [CP_W-1:0] CP_US    = 21'd31;
  localparam logic [CP_W-1:0] CP_DEL   = 21'd127;
  localparam logic [CP_W-1:0] CP_QUOT  = 21'd34;
  localparam logic [CP_W-1:0] CP_AMP   = 21'd38;
  localparam logic [CP_W-1:0] CP_LT    = 21'd60;
  localparam logic [CP_W-1:0] CP_GT    = 21'd62;

  localparam logic [BYTE_W-1:0] CH_AMP  = 8'h26;
  localparam logic [BYTE_W-1:0] CH_HASH = 8'h23;
  localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;

  typedef enum logic [2:0] {
    K_PASS,
    K_LT,
    K_GT,
    K_AMP,
    K_QUOT,
    K_NUM
  } kind_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [CP_W-1:0]    rest;
  } digit_res_t;

  function automatic kind_t classify(input logic [CP_W-1:0] cp);
    kind_t k;
    if (cp > CP_DEL || cp < CP_HT || (cp > CP_CR && cp <= CP_US) || cp == CP_DEL) begin
      k = K_NUM;
    end else if (cp == CP_LT) begin
      k = K_LT;
    end else if (cp == CP_GT) begin
      k = K_GT;
    end else if (cp == CP_AMP) begin
      k = K_AMP;
    end else if (cp == CP_QUOT) begin
      k = K_QUOT;
    end else begin
      k = K_PASS;
    end
    return k;
  endfunction

  // power of ten of the leading decimal digit
  function automatic logic [POS_W-1:0] top_pos(input logic [CP_W-1:0] cp);
    logic [POS_W-1:0] n;
    n = '0;
    if (cp >= 21'd10)      n = 3'd1;
    if (cp >= 21'd100)     n = 3'd2;
    if (cp >= 21'd1000)    n = 3'd3;
    if (cp >= 21'd10000)   n = 3'd4;
    if (cp >= 21'd100000)  n = 3'd5;
    if (cp >= 21'd1000000) n = 3'd6;
    return n;
  endfunction

  function automatic logic [CP_W-1:0] pow10(input logic [POS_W-1:0] pos);
    logic [CP_W-1:0] p;
    case (pos)
      3'd0:    p = 21'd1;
      3'd1:    p = 21'd10;
      3'd2:    p = 21'd100;
      3'd3:    p = 21'd1000;
      3'd4:    p = 21'd10000;
      3'd5:    p = 21'd100000;
      3'd6:    p = 21'd1000000;
      default: p = 21'd1;
    endcase
    return p;
  endfunction

  // byte count of the escaped text
  function automatic logic [IDX_W-1:0] ent_len(input kind_t k, input logic [POS_W-1:0] top);
    logic [IDX_W-1:0] n;
    case (k)
      K_PASS:  n = 4'd1;
      K_LT:    n = 4'd4;
      K_GT:    n = 4'd4;
      K_AMP:   n = 4'd5;
      K_QUOT:  n = 4'd6;
      K_NUM:   n = IDX_W'(top) + 4'd4;
      default: n = 4'd1;
    endcase
    return n;
  endfunction

  // bytes of the named entities
  function automatic logic [BYTE_W-1:0] ent_char(input kind_t k, input logic [IDX_W-1:0] idx);
    logic [6*BYTE_W-1:0] s;
    logic [6*BYTE_W-1:0] sh;
    case (k)
      K_LT:    s = {"&lt;", 16'h0};
      K_GT:    s = {"&gt;", 16'h0};
      K_AMP:   s = {"&amp;", 8'h0};
      K_QUOT:  s = "&quot;";
      default: s = '0;
    endcase
    sh = s << {idx, 3'b000};
    return sh[6*BYTE_W-1 -: BYTE_W];
  endfunction

endpackage

`default_nettype wire

// ===== design/hee_ifs.sv =====
// ----------------------------------------------------------------------------
// hee_ifs
// Valid/ready channels of the escaper: code points in, text bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cp_if import hee_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface byte_if import hee_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== design/hee_digit.sv =====
// ----------------------------------------------------------------------------
// hee_digit
// Extracts one decimal digit at a given power of ten and the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module hee_digit import hee_pkg::*; (
  input  logic [CP_W-1:0]  residue,
  input  logic [POS_W-1:0] pos,
  output digit_res_t       res
);

  logic [CP_W-1:0]         base;
  logic [CP_W-1:0]         sub;
  logic [CP_W+DIGIT_W-1:0] mult;
  logic [DIGIT_W-1:0]      d;

  always_comb begin
    base = pow10(pos);
    sub  = '0;
    d    = '0;
    mult = '0;
    // largest multiple of the power not above the residue
    for (int m = 1; m <= 9; m++) begin
      mult = (CP_W+DIGIT_W)'(base) * (CP_W+DIGIT_W)'(m);
      if ({{DIGIT_W{1'b0}}, residue} >= mult) begin
        sub = mult[CP_W-1:0];
        d   = DIGIT_W'(m);
      end
    end
    res.digit = d;
    res.rest  = residue - sub;
  end

endmodule

`default_nettype wire

// ===== design/html_entity_escaper.sv =====
// ----------------------------------------------------------------------------
// html_entity_escaper
// Escapes one Unicode code point per beat into HTML-safe text bytes.
// ----------------------------------------------------------------------------
// code : one code point per beat (valid/ready)
// text : one byte per beat, last_byte marks the final byte of a code point
// '<' '>' '&' '"' become named entities, code points above 127 and the
// non-whitespace control characters become "&#N;", the rest passes through.
// the code point is registered, then its first byte is registered for output
// throughput: one byte per cycle while text is ready, a code point emits 1
// to 10 bytes by its kind; a new code point is taken in the cycle its last
// byte enters the output register
// decimal digits are produced most significant first, one per byte cycle
// reset: synchronous, drops any item in flight and clears text valid
// stall: the output register holds its byte while ready is low and the
// code channel backs up behind the item being emitted
// ----------------------------------------------------------------------------
`default_nettype none

module html_entity_escaper import hee_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  cp_if.sink     code,
  byte_if.source text
);

  logic              busy;
  kind_t             kind;
  logic [POS_W-1:0]  top;
  logic [POS_W-1:0]  pos;
  logic [IDX_W-1:0]  idx;
  logic [CP_W-1:0]   residue;

  logic              advance;
  logic              last_gen;
  logic              load;
  logic [IDX_W-1:0]  len;
  logic [BYTE_W-1:0] byte_gen;
  digit_res_t        dres;

  hee_digit u_digit (
    .residue (residue),
    .pos     (pos),
    .res     (dres)
  );

  assign len        = ent_len(kind, top);
  assign last_gen   = (idx == len - 4'd1);
  assign advance    = busy && (!text.valid || text.ready);
  assign code.ready = !busy || (advance && last_gen);
  assign load       = code.valid && code.ready;

  always_comb begin
    case (kind)
      K_PASS: begin
        byte_gen = residue[BYTE_W-1:0];
      end
      K_NUM: begin
        if (idx == 4'd0) begin
          byte_gen = CH_AMP;
        end else if (idx == 4'd1) begin
          byte_gen = CH_HASH;
        end else if (last_gen) begin
          byte_gen = CH_SEMI;
        end else begin
          byte_gen = CH_ZERO + BYTE_W'(dres.digit);
        end
      end
      default: begin
        byte_gen = ent_char(kind, idx);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      text.valid <= 1'b0;
    end else begin
      if (load) begin
        busy    <= 1'b1;
        kind    <= classify(code.char_code);
        top     <= top_pos(code.char_code);
        pos     <= top_pos(code.char_code);
        idx     <= '0;
        residue <= code.char_code;
      end else if (advance && last_gen) begin
        busy <= 1'b0;
      end else if (advance) begin
        idx <= idx + 4'd1;
        if (kind == K_NUM && idx >= 4'd2) begin
          residue <= dres.rest;
          if (pos != '0) begin
            pos <= pos - 3'd1;
          end
        end
      end

      if (advance) begin
        text.valid     <= 1'b1;
        text.out_byte  <= byte_gen;
        text.last_byte <= last_gen;
      end else if (text.ready) begin
        text.valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/hee_checker.sv =====
// ----------------------------------------------------------------------------
// hee_checker
// Port-level checks of the escaper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hee_checker import hee_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              code_valid,
  input logic              code_ready,
  input logic              text_valid,
  input logic              text_ready,
  input logic [BYTE_W-1:0] out_byte,
  input logic              last_byte
);

  // stalled beat holds
  assert property (@(posedge clk) disable iff (rst)
    text_valid && !text_ready |=> text_valid && $stable(out_byte) && $stable(last_byte))
    else $error("text beat changed under stall");

  // reset empties the output
  assert property (@(posedge clk) rst |=> !text_valid)
    else $error("text valid after reset");

  // an ampersand always opens an entity
  assert property (@(posedge clk) disable iff (rst)
    text_valid && out_byte == CH_AMP |-> !last_byte)
    else $error("ampersand marked as last byte");

  // a semicolon only ever closes a code point
  assert property (@(posedge clk) disable iff (rst)
    text_valid && out_byte == CH_SEMI |-> last_byte)
    else $error("semicolon not marked as last byte");

  // a code point is never taken while a non-final byte waits
  assert property (@(posedge clk) disable iff (rst)
    text_valid && !text_ready && !last_byte |-> !(code_valid && code_ready))
    else $error("code point taken mid-entity");

endmodule

bind html_entity_escaper hee_checker u_hee_checker (
  .clk        (clk),
  .rst        (rst),
  .code_valid (code.valid),
  .code_ready (code.ready),
  .text_valid (text.valid),
  .text_ready (text.ready),
  .out_byte   (text.out_byte),
  .last_byte  (text.last_byte)
);

`default_nettype wire

// ===== tb/tb_html_entity_escaper.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_html_entity_escaper
// Feeds code points into the escaper and checks every text byte it returns
// against escaped text worked out in the bench, beat by beat, under
// directed corner values, random traffic, random idle cycles on both
// channels and one long output hold-off.
// ----------------------------------------------------------------------------

module tb_html_entity_escaper;
  import hee_pkg::*;

  localparam int HOLD_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_byte;
  } text_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cp_if   code_ch ();
  byte_if text_ch ();

  html_entity_escaper u_dut (
    .clk  (clk),
    .rst  (rst),
    .code (code_ch),
    .text (text_ch)
  );

  logic [CP_W-1:0] chars_to_send[$];
  text_beat_t      escaped_bytes_due[$];
  text_beat_t      due_beat;
  int unsigned     send_gap_pct   = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     hold_requests  = 0;
  int unsigned     holds_served;
  int unsigned     hold_left;
  int unsigned     quiet_cycles;
  int unsigned     fail_count     = 0;

  logic [CP_W-1:0] corner_cps [25] = '{
    21'd0, 21'd8, 21'd9, 21'd10, 21'd13, 21'd14, 21'd31, 21'd32, 21'd33,
    CP_QUOT, CP_AMP, CP_LT, CP_GT, 21'd65, 21'd126, CP_DEL, 21'd128,
    21'd255, 21'h00D800, 21'h00DFFF, 21'd99999, 21'd1000000, 21'd1114111,
    21'd1114112, 21'h1FFFFF
  };

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // escaped text of one code point, queued byte by byte
  function automatic void expect_escaped(input logic [CP_W-1:0] cp);
    string      s;
    int         n;
    text_beat_t beat;
    bit         numeric;
    numeric = (cp > 21'd127) || !((cp >= 21'd32 && cp <= 21'd126) ||
                                  (cp >= 21'd9 && cp <= 21'd13));
    if (numeric) begin
      s = $sformatf("&#%0d;", cp);
    end else begin
      case (cp)
        CP_LT:   s = "&lt;";
        CP_GT:   s = "&gt;";
        CP_AMP:  s = "&amp;";
        CP_QUOT: s = "&quot;";
        default: s = "";
      endcase
    end
    if (s.len() == 0) begin
      beat.out_byte  = cp[BYTE_W-1:0];
      beat.last_byte = 1'b1;
      escaped_bytes_due.push_back(beat);
    end else begin
      n = s.len();
      for (int i = 0; i < n; i++) begin
        beat.out_byte  = s[i];
        beat.last_byte = (i == n - 1);
        escaped_bytes_due.push_back(beat);
      end
    end
  endfunction

  function automatic logic [CP_W-1:0] random_cp();
    int unsigned p;
    case ($urandom_range(5))
      0: return CP_W'($urandom_range(127));
      1: begin
        case ($urandom_range(3))
          0:       return CP_LT;
          1:       return CP_GT;
          2:       return CP_AMP;
          default: return CP_QUOT;
        endcase
      end
      2: return CP_W'($urandom_range(126, 32));
      3: return CP_W'($urandom_range(16'hFFFF, 128));
      4: return CP_W'($urandom_range(21'h1FFFFF));
      default: begin
        // digit count boundaries
        p = 10 ** $urandom_range(6, 1);
        return CP_W'(p - $urandom_range(1));
      end
    endcase
  endfunction

  task automatic run_phase(input int unsigned gap_pct, input int unsigned stall_pct,
                           input int unsigned n_items, input bit hold_off);
    @(negedge clk);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    if (hold_off) hold_requests++;
    for (int i = 0; i < n_items; i++) chars_to_send.push_back(random_cp());
    while (chars_to_send.size() != 0 || code_ch.valid || escaped_bytes_due.size() != 0)
      @(negedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      code_ch.valid <= 1'b0;
    end else begin
      if (code_ch.valid && code_ch.ready) expect_escaped(code_ch.char_code);
      if (!code_ch.valid || code_ch.ready) begin
        if (chars_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          code_ch.valid     <= 1'b1;
          code_ch.char_code <= chars_to_send.pop_front();
        end else begin
          code_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      text_ch.ready <= 1'b0;
      holds_served  <= 0;
      hold_left     <= 0;
    end else if (holds_served != hold_requests) begin
      holds_served  <= holds_served + 1;
      hold_left     <= HOLD_CYCLES;
      text_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      text_ch.ready <= 1'b0;
    end else begin
      text_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // text beat checker
  always @(posedge clk) begin
    if (!rst && text_ch.valid && text_ch.ready) begin
      if (escaped_bytes_due.size() == 0) begin
        $error("text beat with nothing due: out_byte %h last_byte %b",
               text_ch.out_byte, text_ch.last_byte);
        fail_count++;
      end else begin
        due_beat = escaped_bytes_due.pop_front();
        if (text_ch.out_byte !== due_beat.out_byte) begin
          $error("out_byte: expected %h, got %h", due_beat.out_byte, text_ch.out_byte);
          fail_count++;
        end
        if (text_ch.last_byte !== due_beat.last_byte) begin
          $error("last_byte: expected %b, got %b", due_beat.last_byte, text_ch.last_byte);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (code_ch.valid && code_ch.ready) || (text_ch.valid && text_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("html_entity_escaper test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    code_ch.valid     = 1'b0;
    code_ch.char_code = '0;
    text_ch.ready     = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    foreach (corner_cps[i]) chars_to_send.push_back(corner_cps[i]);
    run_phase(0, 0, 40, 1'b0);
    run_phase(85, 0, 40, 1'b0);
    run_phase(0, 85, 40, 1'b0);
    run_phase(36, 36, 40, 1'b0);
    run_phase(0, 0, 40, 1'b1);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && escaped_bytes_due.size() == 0) begin
      $display("html_entity_escaper test passed");
    end else begin
      $display("html_entity_escaper test failed");
    end
    $finish;
  end

endmodule
